>>> design/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types, constants and inverse-scan tables of the scaling list decoder.
// ----------------------------------------------------------------------------
package sld_pkg;

    localparam int MAX_ENTRIES_DEF = 64;

    localparam int SCALE_W  = 8;
    localparam int INDEX_W  = 6;
    localparam int POS_W    = 3;
    localparam int LEN_W    = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LIST_IS_8X8 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_SCAN  = 2'd1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_FILL
    } sld_state_t;

    // table entries are {first, second}
    localparam logic [5:0] SCAN4_ZIGZAG [16] = '{
        6'o00, 6'o01, 6'o10, 6'o20, 6'o11, 6'o02, 6'o03, 6'o12,
        6'o21, 6'o30, 6'o31, 6'o22, 6'o13, 6'o23, 6'o32, 6'o33
    };

    localparam logic [5:0] SCAN4_FIELD [16] = '{
        6'o00, 6'o10, 6'o01, 6'o20, 6'o30, 6'o11, 6'o21, 6'o31,
        6'o02, 6'o12, 6'o22, 6'o32, 6'o03, 6'o13, 6'o23, 6'o33
    };

    localparam logic [5:0] SCAN8_ZIGZAG [64] = '{
        6'o00, 6'o01, 6'o10, 6'o20, 6'o11, 6'o02, 6'o03, 6'o12,
        6'o21, 6'o30, 6'o40, 6'o31, 6'o22, 6'o13, 6'o04, 6'o05,
        6'o14, 6'o23, 6'o32, 6'o41, 6'o50, 6'o60, 6'o51, 6'o42,
        6'o33, 6'o24, 6'o15, 6'o06, 6'o07, 6'o16, 6'o25, 6'o34,
        6'o43, 6'o52, 6'o61, 6'o70, 6'o71, 6'o62, 6'o53, 6'o44,
        6'o35, 6'o26, 6'o17, 6'o27, 6'o36, 6'o45, 6'o54, 6'o63,
        6'o72, 6'o73, 6'o64, 6'o55, 6'o46, 6'o37, 6'o47, 6'o56,
        6'o65, 6'o74, 6'o75, 6'o66, 6'o57, 6'o67, 6'o76, 6'o77
    };

    localparam logic [5:0] SCAN8_FIELD [64] = '{
        6'o00, 6'o10, 6'o20, 6'o01, 6'o11, 6'o30, 6'o40, 6'o21,
        6'o02, 6'o31, 6'o50, 6'o60, 6'o70, 6'o41, 6'o12, 6'o03,
        6'o22, 6'o51, 6'o61, 6'o71, 6'o32, 6'o13, 6'o04, 6'o23,
        6'o42, 6'o52, 6'o62, 6'o72, 6'o33, 6'o14, 6'o05, 6'o24,
        6'o43, 6'o53, 6'o63, 6'o73, 6'o34, 6'o15, 6'o06, 6'o25,
        6'o44, 6'o54, 6'o64, 6'o74, 6'o35, 6'o16, 6'o26, 6'o45,
        6'o55, 6'o65, 6'o75, 6'o36, 6'o07, 6'o17, 6'o46, 6'o56,
        6'o66, 6'o76, 6'o27, 6'o37, 6'o47, 6'o57, 6'o67, 6'o77
    };

    // matrix position of a scan index
    function automatic logic [5:0] scan_pos(
        input logic               is_8x8,
        input logic               field,
        input logic [INDEX_W-1:0] idx
    );
        logic [5:0] pos;
        if (is_8x8)
        begin
            pos = field ? SCAN8_FIELD[idx] : SCAN8_ZIGZAG[idx];
        end
        else
        begin
            pos = field ? SCAN4_FIELD[idx[3:0]] : SCAN4_ZIGZAG[idx[3:0]];
        end
        return pos;
    endfunction

endpackage

>>> design/scaling_list_decoder_core.sv
// ----------------------------------------------------------------------------
// scaling_list_decoder_core
// Scaling list decoder: builds 4x4 or 8x8 list entries from scale deltas.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one signed scale delta per word.
// Output channel (out_valid/out_ready) gives one list entry per word: value,
// scan index, matrix position, use-default flag and last-of-list mark.
// Config channel (cfg_valid/cfg_ready) is always ready; index 0 selects the
// 8x8 list, index 1 the field scan. Write it only between lists.
// A delta giving a non-zero scale yields one entry, registered at the output
// in the cycle after the input word is taken; a new delta can be taken each
// cycle while the output is drained.
// A delta giving a zero scale starts the fill run: one entry per cycle from
// the output register while it is drained, to the last entry, input held off.
// The run length is set by the single entry counter that walks the list.
// A stalled receiver holds the output register and with it the whole block.
// Reset empties the output, selects 4x4 zig-zag and starts a fresh list.
// ----------------------------------------------------------------------------
module scaling_list_decoder_core #(
    parameter int MAX_ENTRIES = sld_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sld_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                            cfg_data,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [sld_pkg::SCALE_W-1:0] scale_delta,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sld_pkg::SCALE_W-1:0]     scale_value,
    output logic [sld_pkg::INDEX_W-1:0]     entry_index,
    output logic [sld_pkg::POS_W-1:0]       matrix_first_index,
    output logic [sld_pkg::POS_W-1:0]       matrix_second_index,
    output logic                            use_default,
    output logic                            last
);

    localparam int LEN_8X8 = (MAX_ENTRIES < 64) ? MAX_ENTRIES : 64;
    localparam int LEN_4X4 = (MAX_ENTRIES < 16) ? MAX_ENTRIES : 16;

    sld_pkg::sld_state_t state_reg, state_next;

    logic list_is_8x8_reg;
    logic field_scan_reg;

    logic [sld_pkg::SCALE_W-1:0] prev_scale_reg, prev_scale_next;
    logic [sld_pkg::INDEX_W-1:0] counter_reg, counter_next;
    logic                        dflt_reg, dflt_next;

    logic                        out_valid_reg, out_valid_next;
    logic [sld_pkg::SCALE_W-1:0] out_scale_reg, out_scale_next;
    logic [sld_pkg::INDEX_W-1:0] out_index_reg, out_index_next;
    logic [5:0]                  out_pos_reg, out_pos_next;
    logic                        out_dflt_reg, out_dflt_next;
    logic                        out_last_reg, out_last_next;

    logic [sld_pkg::LEN_W-1:0]   list_len;
    logic [sld_pkg::SCALE_W-1:0] next_scale;
    logic                        is_last;
    logic                        out_free;
    logic                        dflt_now;
    logic [5:0]                  pos;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_is_8x8_reg <= 1'b0;
            field_scan_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sld_pkg::REG_LIST_IS_8X8: list_is_8x8_reg <= cfg_data;
                sld_pkg::REG_FIELD_SCAN:  field_scan_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign list_len   = list_is_8x8_reg ? sld_pkg::LEN_W'(LEN_8X8)
                                        : sld_pkg::LEN_W'(LEN_4X4);
    assign next_scale = prev_scale_reg + scale_delta;
    assign is_last    = ({1'b0, counter_reg} + 7'd1) >= list_len;
    assign out_free   = !out_valid_reg || out_ready;
    assign pos        = sld_pkg::scan_pos(list_is_8x8_reg, field_scan_reg, counter_reg);
    assign dflt_now   = (counter_reg == '0) ? (next_scale == '0) : dflt_reg;
    assign in_ready   = (state_reg == sld_pkg::ST_IDLE) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sld_pkg::ST_IDLE;
            prev_scale_reg <= sld_pkg::SCALE_RESET;
            counter_reg    <= '0;
            dflt_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_scale_reg <= prev_scale_next;
            counter_reg    <= counter_next;
            dflt_reg       <= dflt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_scale_reg <= out_scale_next;
        out_index_reg <= out_index_next;
        out_pos_reg   <= out_pos_next;
        out_dflt_reg  <= out_dflt_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        prev_scale_next = prev_scale_reg;
        counter_next    = counter_reg;
        dflt_next       = dflt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_scale_next  = out_scale_reg;
        out_index_next  = out_index_reg;
        out_pos_next    = out_pos_reg;
        out_dflt_next   = out_dflt_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            sld_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = counter_reg;
                    out_pos_next   = pos;
                    out_dflt_next  = dflt_now;
                    out_last_next  = is_last;
                    dflt_next      = dflt_now;
                    if (next_scale != '0)
                    begin
                        out_scale_next  = next_scale;
                        prev_scale_next = next_scale;
                    end
                    else
                    begin
                        // zero scale: repeat the last scale to the end of the list
                        out_scale_next = prev_scale_reg;
                        if (!is_last)
                        begin
                            state_next = sld_pkg::ST_FILL;
                        end
                    end
                    if (is_last)
                    begin
                        prev_scale_next = sld_pkg::SCALE_RESET;
                        counter_next    = '0;
                        dflt_next       = 1'b0;
                    end
                    else
                    begin
                        counter_next = counter_reg + 6'd1;
                    end
                end
            end
            sld_pkg::ST_FILL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_scale_next = prev_scale_reg;
                    out_index_next = counter_reg;
                    out_pos_next   = pos;
                    out_dflt_next  = dflt_reg;
                    out_last_next  = is_last;
                    if (is_last)
                    begin
                        state_next      = sld_pkg::ST_IDLE;
                        prev_scale_next = sld_pkg::SCALE_RESET;
                        counter_next    = '0;
                        dflt_next       = 1'b0;
                    end
                    else
                    begin
                        counter_next = counter_reg + 6'd1;
                    end
                end
            end
            default:
            begin
                state_next = sld_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid           = out_valid_reg;
    assign scale_value         = out_scale_reg;
    assign entry_index         = out_index_reg;
    assign matrix_first_index  = out_pos_reg[5:3];
    assign matrix_second_index = out_pos_reg[2:0];
    assign use_default         = out_dflt_reg;
    assign last                = out_last_reg;

endmodule

>>> sim/scaling_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scaling_list_checker
// Watches the config, delta and entry channels of the scaling list decoder.
// Every accepted delta is decoded here into the list entries it should give,
// and every accepted entry is compared field by field with the oldest one due.
// ----------------------------------------------------------------------------
module scaling_list_checker #(
    parameter int MAX_ENTRIES = sld_pkg::MAX_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [sld_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic                               cfg_data,

    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic signed [sld_pkg::SCALE_W-1:0] scale_delta,

    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [sld_pkg::SCALE_W-1:0]        scale_value,
    input  logic [sld_pkg::INDEX_W-1:0]        entry_index,
    input  logic [sld_pkg::POS_W-1:0]          matrix_first_index,
    input  logic [sld_pkg::POS_W-1:0]          matrix_second_index,
    input  logic                               use_default,
    input  logic                               last,

    output int                                 mismatches,
    output int                                 entries_due
);

    typedef struct packed {
        logic [sld_pkg::SCALE_W-1:0] scale;
        logic [sld_pkg::INDEX_W-1:0] index;
        logic [sld_pkg::POS_W-1:0]   row;
        logic [sld_pkg::POS_W-1:0]   col;
        logic                        dflt;
        logic                        fin;
    } list_entry_t;

    // field scans have no simple rule, so they are tabled as {row, col}
    localparam logic [5:0] FIELD4_POS [16] = '{
        6'o00, 6'o10, 6'o01, 6'o20, 6'o30, 6'o11, 6'o21, 6'o31,
        6'o02, 6'o12, 6'o22, 6'o32, 6'o03, 6'o13, 6'o23, 6'o33
    };

    localparam logic [5:0] FIELD8_POS [64] = '{
        6'o00, 6'o10, 6'o20, 6'o01, 6'o11, 6'o30, 6'o40, 6'o21,
        6'o02, 6'o31, 6'o50, 6'o60, 6'o70, 6'o41, 6'o12, 6'o03,
        6'o22, 6'o51, 6'o61, 6'o71, 6'o32, 6'o13, 6'o04, 6'o23,
        6'o42, 6'o52, 6'o62, 6'o72, 6'o33, 6'o14, 6'o05, 6'o24,
        6'o43, 6'o53, 6'o63, 6'o73, 6'o34, 6'o15, 6'o06, 6'o25,
        6'o44, 6'o54, 6'o64, 6'o74, 6'o35, 6'o16, 6'o26, 6'o45,
        6'o55, 6'o65, 6'o75, 6'o36, 6'o07, 6'o17, 6'o46, 6'o56,
        6'o66, 6'o76, 6'o27, 6'o37, 6'o47, 6'o57, 6'o67, 6'o77
    };

    logic                        list_8x8;
    logic                        field_mode;
    logic [sld_pkg::SCALE_W-1:0] prev_scale;
    logic [sld_pkg::INDEX_W-1:0] entry_count;
    logic                        default_seen;
    list_entry_t                 pending_entries[$];
    list_entry_t                 got_word;

    // walk the anti-diagonals of an n x n block; odd diagonals run with rising row
    function automatic logic [5:0] zigzag_pos(input int n, input int k);
        int d;
        int lo;
        int hi;
        int seen;
        int row;
        logic [5:0] pos;
        seen = 0;
        pos  = '0;
        for (d = 0; d <= 2 * n - 2; d++)
        begin
            lo = (d >= n) ? d - n + 1 : 0;
            hi = (d < n) ? d : n - 1;
            if (k >= seen && k < seen + hi - lo + 1)
            begin
                row = d[0] ? lo + (k - seen) : hi - (k - seen);
                pos = {3'(row), 3'(d - row)};
            end
            seen += hi - lo + 1;
        end
        return pos;
    endfunction

    task automatic start_new_list();
        prev_scale   = sld_pkg::SCALE_RESET;
        entry_count  = '0;
        default_seen = 1'b0;
    endtask

    task automatic queue_entry(input logic [sld_pkg::SCALE_W-1:0] value, input logic fin);
        logic [5:0]  pos;
        list_entry_t w;
        if (list_8x8)
        begin
            pos = field_mode ? FIELD8_POS[entry_count] : zigzag_pos(8, entry_count);
        end
        else
        begin
            pos = field_mode ? FIELD4_POS[entry_count[3:0]]
                             : zigzag_pos(4, entry_count[3:0]);
        end
        w.scale = value;
        w.index = entry_count;
        w.row   = pos[5:3];
        w.col   = pos[2:0];
        w.dflt  = default_seen;
        w.fin   = fin;
        pending_entries.push_back(w);
    endtask

    // one delta gives one entry, or a zero scale fills out the rest of the list
    task automatic decode_delta(input logic [sld_pkg::SCALE_W-1:0] d);
        logic [sld_pkg::SCALE_W-1:0] nxt;
        int                          len;
        int                          n;
        logic                        fin;
        len = list_8x8 ? 64 : 16;
        if (len > MAX_ENTRIES)
        begin
            len = MAX_ENTRIES;
        end
        nxt = prev_scale + d;
        if (entry_count == 0)
        begin
            default_seen = (nxt == 0);
        end
        if (nxt != 0)
        begin
            fin = int'(entry_count) + 1 >= len;
            queue_entry(nxt, fin);
            prev_scale  = nxt;
            entry_count = entry_count + 1'b1;
            if (fin)
            begin
                start_new_list();
            end
        end
        else
        begin
            n = 0;
            do
            begin
                fin = (int'(entry_count) + 1 >= len) || (n >= 63);
                queue_entry(prev_scale, fin);
                n++;
                if (!fin)
                begin
                    entry_count = entry_count + 1'b1;
                end
            end
            while (!fin);
            start_new_list();
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] expv,
                               input logic [7:0] actv);
        if (actv !== expv)
        begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_8x8   = 1'b0;
            field_mode = 1'b0;
            start_new_list();
            pending_entries.delete();
            entries_due = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sld_pkg::REG_LIST_IS_8X8: list_8x8   = cfg_data;
                    sld_pkg::REG_FIELD_SCAN:  field_mode = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                decode_delta(scale_delta);
            end

            if (out_valid && out_ready)
            begin
                if (pending_entries.size() == 0)
                begin
                    $error("scale_value: no entry due, got %0d at index %0d",
                           scale_value, entry_index);
                    mismatches++;
                end
                else
                begin
                    got_word = pending_entries.pop_front();
                    check_field("scale_value", got_word.scale, scale_value);
                    check_field("entry_index", 8'(got_word.index), 8'(entry_index));
                    check_field("matrix_first_index", 8'(got_word.row),
                                8'(matrix_first_index));
                    check_field("matrix_second_index", 8'(got_word.col),
                                8'(matrix_second_index));
                    check_field("use_default", 8'(got_word.dflt), 8'(use_default));
                    check_field("last", 8'(got_word.fin), 8'(last));
                end
            end

            entries_due = pending_entries.size();
        end
    end

endmodule

>>> sim/tb_scaling_list_decoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scaling_list_decoder_core
// Feeds scale deltas and register writes to the scaling list decoder: first a
// directed run over default lists, fill runs, both scans, both list sizes and
// a size change part way through a list, then random lists under changing
// sender and receiver idling. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_scaling_list_decoder_core;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int ITEMS_PER_PHASE = 38;

    // no register lives at this index
    localparam logic [sld_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                                 clk         = 1'b0;
    logic                                 rst_n       = 1'b0;
    logic                                 cfg_valid   = 1'b0;
    logic                                 cfg_ready;
    logic [sld_pkg::CFG_IDX_W-1:0]        cfg_index   = '0;
    logic                                 cfg_data    = 1'b0;
    logic                                 in_valid    = 1'b0;
    logic                                 in_ready;
    logic signed [sld_pkg::SCALE_W-1:0]   scale_delta = '0;
    logic                                 out_valid;
    logic                                 out_ready   = 1'b0;
    logic [sld_pkg::SCALE_W-1:0]          scale_value;
    logic [sld_pkg::INDEX_W-1:0]          entry_index;
    logic [sld_pkg::POS_W-1:0]            matrix_first_index;
    logic [sld_pkg::POS_W-1:0]            matrix_second_index;
    logic                                 use_default;
    logic                                 last;

    int mismatches;
    int entries_due;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    // where the stimulus stands in the current list, to shape the deltas
    logic [sld_pkg::SCALE_W-1:0] run_scale = sld_pkg::SCALE_RESET;
    int                          run_pos   = 0;
    logic                        run_8x8   = 1'b0;

    scaling_list_decoder_core DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .scale_delta         (scale_delta),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .scale_value         (scale_value),
        .entry_index         (entry_index),
        .matrix_first_index  (matrix_first_index),
        .matrix_second_index (matrix_second_index),
        .use_default         (use_default),
        .last                (last)
    );

    scaling_list_checker checker_i (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .scale_delta         (scale_delta),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .scale_value         (scale_value),
        .entry_index         (entry_index),
        .matrix_first_index  (matrix_first_index),
        .matrix_second_index (matrix_second_index),
        .use_default         (use_default),
        .last                (last),
        .mismatches          (mismatches),
        .entries_due         (entries_due)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("tb_scaling_list_decoder_core: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // mostly arbitrary deltas, now and then one that ends the list with a zero
    function automatic logic signed [sld_pkg::SCALE_W-1:0] pick_delta();
        if ($urandom_range(99) < 8)
        begin
            return 8'(0 - run_scale);
        end
        return 8'($urandom);
    endfunction

    function automatic logic signed [sld_pkg::SCALE_W-1:0] nonzero_delta();
        logic signed [sld_pkg::SCALE_W-1:0] d;
        do
        begin
            d = 8'($urandom);
        end
        while (8'(run_scale + d) == 0);
        return d;
    endfunction

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic feed_delta(input logic signed [sld_pkg::SCALE_W-1:0] d);
        logic [sld_pkg::SCALE_W-1:0] nxt;
        nxt = run_scale + d;
        if (nxt == 0 || run_pos + 1 >= (run_8x8 ? 64 : 16))
        begin
            run_scale = sld_pkg::SCALE_RESET;
            run_pos   = 0;
        end
        else
        begin
            run_scale = nxt;
            run_pos++;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        scale_delta <= d;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // registers change only once every entry due has left the block
    task automatic write_reg(input logic [sld_pkg::CFG_IDX_W-1:0] idx, input logic val);
        in_valid <= 1'b0;
        while (entries_due != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == sld_pkg::REG_LIST_IS_8X8)
        begin
            run_8x8 = val;
        end
    endtask

    initial
    begin
        int p;
        int k;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 4x4 zig-zag: default list, then a list that ends in a fill run
        write_reg(sld_pkg::REG_LIST_IS_8X8, 1'b0);
        write_reg(sld_pkg::REG_FIELD_SCAN, 1'b0);
        write_reg(REG_UNUSED, 1'b1);
        feed_delta(-8'sd8);
        feed_delta(8'sd127);
        feed_delta(-8'sd128);
        feed_delta(8'sd0);
        feed_delta(-8'sd1);
        feed_delta(-8'sd6);

        // field scans, 4x4 then 8x8, both as default lists
        write_reg(sld_pkg::REG_FIELD_SCAN, 1'b1);
        feed_delta(-8'sd8);
        write_reg(sld_pkg::REG_LIST_IS_8X8, 1'b1);
        feed_delta(-8'sd8);

        // 8x8 zig-zag, fill run of 63 entries from the second word
        write_reg(sld_pkg::REG_FIELD_SCAN, 1'b0);
        feed_delta(-8'sd128);
        feed_delta(8'sd120);

        // list shrinks to 4x4 with the counter already past its end
        for (k = 0; k < 16; k++)
        begin
            feed_delta(nonzero_delta());
        end
        write_reg(sld_pkg::REG_LIST_IS_8X8, 1'b0);
        feed_delta(pick_delta());

        for (p = 0; p < 4; p++)
        begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (run_pos == 0 && $urandom_range(99) < 25)
                begin
                    write_reg(sld_pkg::CFG_IDX_W'($urandom_range(3)),
                              1'($urandom_range(1)));
                end
                else if (run_pos != 0 && $urandom_range(99) < 3)
                begin
                    write_reg(sld_pkg::REG_LIST_IS_8X8, !run_8x8);
                end
                feed_delta(pick_delta());
            end
        end

        in_valid <= 1'b0;
        while (entries_due != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES * 2) @(negedge clk);

        if (mismatches == 0)
        begin
            $display("tb_scaling_list_decoder_core: clean");
        end
        else
        begin
            $display("tb_scaling_list_decoder_core: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/sld_pkg.sv
design/scaling_list_decoder_core.sv
sim/scaling_list_checker.sv
sim/tb_scaling_list_decoder_core.sv
